/* sv/lpmr_pkg.sv */
`timescale 1ns / 1ps

package lpmr_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int LINE_WIDTH    = 8;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ADDR_W        = 32;
    localparam int PLEN_W        = 6;
    localparam int IN_LINE_W     = 8;
    localparam int IN_IDX_W      = 3;

    localparam logic       FUNC_WRITE  = 1'b0;
    localparam logic       FUNC_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        t_S_IDLE = 2'd0,
        t_S_SCAN = 2'd1,
        t_S_DONE = 2'd2
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_status;

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
        logic [ADDR_W-1:0] ones;
        ones = '1;
        return ~(ones >> len);
    endfunction

endpackage

/* sv/longest_prefix_match_router.sv */
`timescale 1ns / 1ps
// ipv4 longest prefix match over a table of 8 routes
// input channel (i_in_valid / o_in_ready): one transaction is either a route
//   write (i_func = 0: slot, enable, network, prefix length, line) or a lookup
//   (i_func = 1: destination address)
// output channel (o_out_valid / i_out_ready): one transaction per lookup with
//   found flag, winning line and prefix length; writes give no transaction
// a write leaves the controller idle, so the block stays ready for the next transaction
// a lookup walks the table one entry per cycle through a single compare unit:
//   the scan state steps through all 8 entries, then the done state loads the
//   output register and the controller returns to idle; no new transaction is
//   taken while a lookup is still in progress
// the output register holds a finished result while the next transaction is
//   taken; a lookup that ends while that register is still full waits for the
//   receiver before it is loaded, and input stays blocked meanwhile
// reset (i_rst_n low, synchronous) clears all route valid bits, the
//   controller and the output valid flag
module longest_prefix_match_router (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_func,
    input  logic [lpmr_pkg::IN_IDX_W-1:0]   i_entry_index,
    input  logic                            i_entry_enable,
    input  logic [lpmr_pkg::ADDR_W-1:0]     i_entry_network,
    input  logic [lpmr_pkg::PLEN_W-1:0]     i_entry_prefix_len,
    input  logic [lpmr_pkg::IN_LINE_W-1:0]  i_entry_line,
    input  logic [lpmr_pkg::ADDR_W-1:0]     i_dest_addr,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_found,
    output logic [lpmr_pkg::IN_LINE_W-1:0]  o_out_line,
    output logic [lpmr_pkg::PLEN_W-1:0]     o_out_prefix_len
);

    lpmr_pkg::t_cmd    cmd;
    lpmr_pkg::t_status status;

    lpmr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    lpmr_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_func             (i_func),
        .i_entry_index      (i_entry_index),
        .i_entry_enable     (i_entry_enable),
        .i_entry_network    (i_entry_network),
        .i_entry_prefix_len (i_entry_prefix_len),
        .i_entry_line       (i_entry_line),
        .i_dest_addr        (i_dest_addr),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_found            (o_found),
        .o_out_line         (o_out_line),
        .o_out_prefix_len   (o_out_prefix_len)
    );

endmodule

/* sv/lpmr_ctrl.sv */
`timescale 1ns / 1ps

module lpmr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_func,
    input  lpmr_pkg::t_status i_status,
    output logic              o_in_ready,
    output lpmr_pkg::t_cmd    o_cmd
);

    lpmr_pkg::t_state r_state;
    lpmr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpmr_pkg::t_S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpmr_pkg::t_S_IDLE: begin
                if (i_in_valid && (i_func == lpmr_pkg::FUNC_LOOKUP)) begin
                    n_state = lpmr_pkg::t_S_SCAN;
                end
            end
            lpmr_pkg::t_S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = lpmr_pkg::t_S_DONE;
                end
            end
            lpmr_pkg::t_S_DONE: begin
                if (i_status.out_free) begin
                    n_state = lpmr_pkg::t_S_IDLE;
                end
            end
            default: n_state = lpmr_pkg::t_S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.out_load  = 1'b0;
        unique case (r_state)
            lpmr_pkg::t_S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            lpmr_pkg::t_S_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            lpmr_pkg::t_S_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/lpmr_datapath.sv */
`timescale 1ns / 1ps

module lpmr_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lpmr_pkg::t_cmd                      i_cmd,
    output lpmr_pkg::t_status                   o_status,
    input  logic                                i_func,
    input  logic [lpmr_pkg::IN_IDX_W-1:0]       i_entry_index,
    input  logic                                i_entry_enable,
    input  logic [lpmr_pkg::ADDR_W-1:0]         i_entry_network,
    input  logic [lpmr_pkg::PLEN_W-1:0]         i_entry_prefix_len,
    input  logic [lpmr_pkg::IN_LINE_W-1:0]      i_entry_line,
    input  logic [lpmr_pkg::ADDR_W-1:0]         i_dest_addr,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [lpmr_pkg::IN_LINE_W-1:0]      o_out_line,
    output logic [lpmr_pkg::PLEN_W-1:0]         o_out_prefix_len
);

    logic [lpmr_pkg::TABLE_ENTRIES-1:0] r_valid;
    logic [lpmr_pkg::ADDR_W-1:0]        r_network [lpmr_pkg::TABLE_ENTRIES];
    logic [lpmr_pkg::PLEN_W-1:0]        r_prefix  [lpmr_pkg::TABLE_ENTRIES];
    logic [lpmr_pkg::LINE_WIDTH-1:0]    r_line    [lpmr_pkg::TABLE_ENTRIES];

    logic [lpmr_pkg::IDX_W-1:0]      r_idx;
    logic [lpmr_pkg::ADDR_W-1:0]     r_dest;
    logic                            r_hit;
    logic [lpmr_pkg::PLEN_W-1:0]     r_best_len;
    logic [lpmr_pkg::LINE_WIDTH-1:0] r_best_line;

    logic                            r_out_valid;
    logic                            r_found;
    logic [lpmr_pkg::IN_LINE_W-1:0]  r_out_line;
    logic [lpmr_pkg::PLEN_W-1:0]     r_out_plen;

    logic                            wr_en;
    logic                            wr_in_range;
    logic [lpmr_pkg::IDX_W-1:0]      wr_idx;
    logic [lpmr_pkg::PLEN_W-1:0]     wr_plen;
    logic [lpmr_pkg::ADDR_W-1:0]     mask;
    logic                            match;
    logic                            better;

    assign wr_in_range = (32'(i_entry_index) < 32'(lpmr_pkg::TABLE_ENTRIES));
    assign wr_en       = i_cmd.accept && (i_func == lpmr_pkg::FUNC_WRITE) && wr_in_range;
    assign wr_idx      = lpmr_pkg::IDX_W'(i_entry_index);
    assign wr_plen     = (i_entry_prefix_len > lpmr_pkg::PLEN_W'(lpmr_pkg::ADDR_W))
                       ? lpmr_pkg::PLEN_W'(lpmr_pkg::ADDR_W) : i_entry_prefix_len;

    assign mask   = lpmr_pkg::prefix_mask(r_prefix[r_idx]);
    assign match  = r_valid[r_idx] && (((r_dest ^ r_network[r_idx]) & mask) == '0);
    assign better = match && (!r_hit || (r_prefix[r_idx] > r_best_len));

    assign o_status.scan_last = (r_idx == lpmr_pkg::IDX_W'(lpmr_pkg::TABLE_ENTRIES - 1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_idx] <= i_entry_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && i_entry_enable) begin
            r_network[wr_idx] <= i_entry_network;
            r_prefix[wr_idx]  <= wr_plen;
            r_line[wr_idx]    <= lpmr_pkg::LINE_WIDTH'(i_entry_line);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_hit <= 1'b0;
        end else if (i_cmd.accept) begin
            r_idx <= '0;
            r_hit <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            if (better) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dest      <= i_dest_addr;
            r_best_len  <= '0;
            r_best_line <= '0;
        end else if (i_cmd.scan_step && better) begin
            r_best_len  <= r_prefix[r_idx];
            r_best_line <= r_line[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_found    <= r_hit;
            r_out_line <= r_hit ? lpmr_pkg::IN_LINE_W'(r_best_line) : '0;
            r_out_plen <= r_hit ? r_best_len : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_found;
    assign o_out_line       = r_out_line;
    assign o_out_prefix_len = r_out_plen;

endmodule

/* verif/longest_prefix_match_router_tb.sv */
`timescale 1ns / 1ps

module longest_prefix_match_router_tb;

    localparam int DIR_ROWS   = 26;
    localparam int RAND_ITEMS = 450;
    localparam int CALM_FIRST = DIR_ROWS + 200;
    localparam int CALM_LAST  = DIR_ROWS + 300;
    localparam int LIMIT      = 200000;
    localparam int DRAIN      = 30;

    typedef struct packed {
        logic                           func;
        logic [lpmr_pkg::IN_IDX_W-1:0]  idx;
        logic                           en;
        logic [lpmr_pkg::ADDR_W-1:0]    net;
        logic [lpmr_pkg::PLEN_W-1:0]    plen;
        logic [lpmr_pkg::IN_LINE_W-1:0] line;
        logic [lpmr_pkg::ADDR_W-1:0]    dest;
        logic                           chk;
        logic                           found;
        logic [lpmr_pkg::IN_LINE_W-1:0] eline;
        logic [lpmr_pkg::PLEN_W-1:0]    eplen;
    } t_lpm_row;

    typedef struct packed {
        logic                           found;
        logic [lpmr_pkg::IN_LINE_W-1:0] line;
        logic [lpmr_pkg::PLEN_W-1:0]    plen;
    } t_lpm_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic                           i_func = lpmr_pkg::FUNC_WRITE;
    logic [lpmr_pkg::IN_IDX_W-1:0]  i_entry_index = '0;
    logic                           i_entry_enable = 1'b0;
    logic [lpmr_pkg::ADDR_W-1:0]    i_entry_network = '0;
    logic [lpmr_pkg::PLEN_W-1:0]    i_entry_prefix_len = '0;
    logic [lpmr_pkg::IN_LINE_W-1:0] i_entry_line = '0;
    logic [lpmr_pkg::ADDR_W-1:0]    i_dest_addr = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic                           o_found;
    logic [lpmr_pkg::IN_LINE_W-1:0] o_out_line;
    logic [lpmr_pkg::PLEN_W-1:0]    o_out_prefix_len;

    logic                            tbl_valid [lpmr_pkg::TABLE_ENTRIES];
    logic [lpmr_pkg::ADDR_W-1:0]     tbl_net   [lpmr_pkg::TABLE_ENTRIES];
    logic [lpmr_pkg::PLEN_W-1:0]     tbl_plen  [lpmr_pkg::TABLE_ENTRIES];
    logic [lpmr_pkg::LINE_WIDTH-1:0] tbl_line  [lpmr_pkg::TABLE_ENTRIES];

    t_lpm_result                 pending_lookups[$];
    t_lpm_row                    dir_table [DIR_ROWS];
    logic [lpmr_pkg::ADDR_W-1:0] net_bases [4];
    logic                        calm = 1'b0;
    int                          mismatches = 0;
    int                          cycles = 0;

    longest_prefix_match_router dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_func             (i_func),
        .i_entry_index      (i_entry_index),
        .i_entry_enable     (i_entry_enable),
        .i_entry_network    (i_entry_network),
        .i_entry_prefix_len (i_entry_prefix_len),
        .i_entry_line       (i_entry_line),
        .i_dest_addr        (i_dest_addr),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_found            (o_found),
        .o_out_line         (o_out_line),
        .o_out_prefix_len   (o_out_prefix_len)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("FAIL longest_prefix_match_router");
            $finish;
        end
    end

    function automatic logic [lpmr_pkg::ADDR_W-1:0] route_mask(
            input logic [lpmr_pkg::PLEN_W-1:0] len);
        if (len == 0)
            return '0;
        return {lpmr_pkg::ADDR_W{1'b1}} << (lpmr_pkg::ADDR_W - len);
    endfunction

    function automatic void apply_route_write(input t_lpm_row r);
        if (r.idx < lpmr_pkg::TABLE_ENTRIES) begin
            if (r.en) begin
                tbl_valid[r.idx] = 1'b1;
                tbl_net[r.idx]   = r.net;
                tbl_plen[r.idx]  = (r.plen > lpmr_pkg::ADDR_W)
                                 ? lpmr_pkg::PLEN_W'(lpmr_pkg::ADDR_W) : r.plen;
                tbl_line[r.idx]  = r.line[lpmr_pkg::LINE_WIDTH-1:0];
            end else begin
                tbl_valid[r.idx] = 1'b0;
            end
        end
    endfunction

    function automatic t_lpm_result predict_lookup(input logic [lpmr_pkg::ADDR_W-1:0] dest);
        t_lpm_result best;
        logic [lpmr_pkg::ADDR_W-1:0] m;
        best = '0;
        for (int i = 0; i < lpmr_pkg::TABLE_ENTRIES; i++) begin
            m = route_mask(tbl_plen[i]);
            if (tbl_valid[i] && ((dest & m) == (tbl_net[i] & m))
                    && (!best.found || tbl_plen[i] > best.plen)) begin
                best.found = 1'b1;
                best.line  = lpmr_pkg::IN_LINE_W'(tbl_line[i]);
                best.plen  = tbl_plen[i];
            end
        end
        return best;
    endfunction

    function automatic t_lpm_row random_row();
        t_lpm_row r;
        int live[$];
        int pick;
        int k;
        int b;
        logic [lpmr_pkg::ADDR_W-1:0] m;
        r = '0;
        r.func = ($urandom_range(0, 99) < 35) ? lpmr_pkg::FUNC_WRITE : lpmr_pkg::FUNC_LOOKUP;
        r.idx  = lpmr_pkg::IN_IDX_W'($urandom_range(0, lpmr_pkg::TABLE_ENTRIES - 1));
        r.en   = ($urandom_range(0, 99) < 80);
        k = $urandom_range(0, 99);
        if (k < 8)
            r.plen = lpmr_pkg::PLEN_W'(0);
        else if (k < 16)
            r.plen = lpmr_pkg::PLEN_W'(32);
        else if (k < 24)
            r.plen = lpmr_pkg::PLEN_W'($urandom_range(33, 63));
        else
            r.plen = lpmr_pkg::PLEN_W'($urandom_range(1, 31));
        if ($urandom_range(0, 99) < 60)
            r.net = net_bases[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(8, 31));
        else
            r.net = $urandom;
        r.line = lpmr_pkg::IN_LINE_W'($urandom_range(0, 255));
        r.dest = $urandom;
        if (r.func == lpmr_pkg::FUNC_LOOKUP) begin
            for (int i = 0; i < lpmr_pkg::TABLE_ENTRIES; i++)
                if (tbl_valid[i])
                    live.push_back(i);
            k = $urandom_range(0, 99);
            if (live.size() != 0 && k < 70) begin
                pick = live[$urandom_range(0, live.size() - 1)];
                m = route_mask(tbl_plen[pick]);
                r.dest = (tbl_net[pick] & m) | ($urandom & ~m);
                // knock one bit inside the prefix to get a near miss
                if (k >= 55 && tbl_plen[pick] != 0) begin
                    b = lpmr_pkg::ADDR_W - $urandom_range(1, tbl_plen[pick]);
                    r.dest[b] = ~r.dest[b];
                end
            end else if (k < 85) begin
                r.dest = net_bases[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(4, 31));
            end
        end
        return r;
    endfunction

    task automatic send_item(input t_lpm_row r);
        t_lpm_result typed;
        i_in_valid         <= 1'b1;
        i_func             <= r.func;
        i_entry_index      <= r.idx;
        i_entry_enable     <= r.en;
        i_entry_network    <= r.net;
        i_entry_prefix_len <= r.plen;
        i_entry_line       <= r.line;
        i_dest_addr        <= r.dest;
        do @(posedge i_clk); while (!o_in_ready);
        if (r.func == lpmr_pkg::FUNC_WRITE) begin
            apply_route_write(r);
        end else if (r.chk) begin
            typed.found = r.found;
            typed.line  = r.eline;
            typed.plen  = r.eplen;
            pending_lookups.push_back(typed);
        end else begin
            pending_lookups.push_back(predict_lookup(r.dest));
        end
        if (!calm && $urandom_range(0, 99) < 25) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 25);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_lookups.size() == 0) begin
                    $error("unexpected result transaction: found %0d line %0d prefix %0d",
                           o_found, o_out_line, o_out_prefix_len);
                    mismatches++;
                end else begin
                    if (o_found !== pending_lookups[0].found) begin
                        $error("found: expected %0d, actual %0d",
                               pending_lookups[0].found, o_found);
                        mismatches++;
                    end
                    if (o_out_line !== pending_lookups[0].line) begin
                        $error("out_line: expected %0d, actual %0d",
                               pending_lookups[0].line, o_out_line);
                        mismatches++;
                    end
                    if (o_out_prefix_len !== pending_lookups[0].plen) begin
                        $error("out_prefix_len: expected %0d, actual %0d",
                               pending_lookups[0].plen, o_out_prefix_len);
                        mismatches++;
                    end
                    void'(pending_lookups.pop_front());
                end
            end
            i_out_ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    initial begin
        for (int i = 0; i < lpmr_pkg::TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_net[i]   = '0;
            tbl_plen[i]  = '0;
            tbl_line[i]  = '0;
        end
        for (int i = 0; i < 4; i++)
            net_bases[i] = $urandom;
        dir_table = '{
            // empty table after reset
            '{lpmr_pkg::FUNC_LOOKUP, 3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'h0000_0000,
              1'b1, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_LOOKUP, 3'd7, 1'b1, 32'hFFFF_FFFF, 6'd63, 8'hFF, 32'hFFFF_FFFF,
              1'b1, 1'b0, 8'h00, 6'd0},
            // default route
            '{lpmr_pkg::FUNC_WRITE,  3'd7, 1'b1, 32'h1234_5678, 6'd0,  8'hFF, 32'hFFFF_FFFF,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_LOOKUP, 3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'h0000_0000,
              1'b1, 1'b1, 8'hFF, 6'd0},
            '{lpmr_pkg::FUNC_LOOKUP, 3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'hFFFF_FFFF,
              1'b1, 1'b1, 8'hFF, 6'd0},
            // host route
            '{lpmr_pkg::FUNC_WRITE,  3'd0, 1'b1, 32'hFFFF_FFFF, 6'd32, 8'h00, 32'h0000_0000,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_LOOKUP, 3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'hFFFF_FFFF,
              1'b1, 1'b1, 8'h00, 6'd32},
            '{lpmr_pkg::FUNC_LOOKUP, 3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'hFFFF_FFFE,
              1'b1, 1'b1, 8'hFF, 6'd0},
            // oversized prefix saturates
            '{lpmr_pkg::FUNC_WRITE,  3'd1, 1'b1, 32'h0A00_0000, 6'd63, 8'h11, 32'h0000_0000,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_LOOKUP, 3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'h0A00_0000,
              1'b1, 1'b1, 8'h11, 6'd32},
            '{lpmr_pkg::FUNC_LOOKUP, 3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'h0A00_0001,
              1'b1, 1'b1, 8'hFF, 6'd0},
            // tie on prefix length
            '{lpmr_pkg::FUNC_WRITE,  3'd2, 1'b1, 32'hC0A8_0000, 6'd16, 8'h22, 32'h0000_0000,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_WRITE,  3'd3, 1'b1, 32'hC0A8_FFFF, 6'd16, 8'h33, 32'h0000_0000,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_LOOKUP, 3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'hC0A8_1234,
              1'b1, 1'b1, 8'h22, 6'd16},
            // clearing write
            '{lpmr_pkg::FUNC_WRITE,  3'd2, 1'b0, 32'hFFFF_FFFF, 6'd63, 8'hFF, 32'h0000_0000,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_LOOKUP, 3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'hC0A8_1234,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_WRITE,  3'd4, 1'b1, 32'hC0A8_1200, 6'd24, 8'h44, 32'h0000_0000,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_LOOKUP, 3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'hC0A8_12FF,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_WRITE,  3'd5, 1'b1, 32'h8000_0000, 6'd1,  8'h55, 32'h0000_0000,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_LOOKUP, 3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'h8000_0000,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_WRITE,  3'd6, 1'b1, 32'h0000_0000, 6'd33, 8'h66, 32'h0000_0000,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_LOOKUP, 3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'h0000_0000,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_WRITE,  3'd7, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'h0000_0000,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_LOOKUP, 3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'h7FFF_FFFF,
              1'b1, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_WRITE,  3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'h0000_0000,
              1'b0, 1'b0, 8'h00, 6'd0},
            '{lpmr_pkg::FUNC_LOOKUP, 3'd0, 1'b0, 32'h0000_0000, 6'd0,  8'h00, 32'hFFFF_FFFF,
              1'b0, 1'b0, 8'h00, 6'd0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIR_ROWS + RAND_ITEMS; n++) begin
            calm <= (n >= CALM_FIRST && n < CALM_LAST);
            if (n < DIR_ROWS)
                send_item(dir_table[n]);
            else
                send_item(random_row());
        end
        i_in_valid <= 1'b0;

        while (pending_lookups.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASS longest_prefix_match_router");
        else
            $display("FAIL longest_prefix_match_router");
        $finish;
    end

endmodule
